[hw/rtl/tlqe_pkg.sv]
// Shared types, widths and constants of the thick line quad expander.
package tlqe_pkg;

    // Screen coordinates in Q.8, wide enough for any camera offset and scale
    localparam int CW     = 37;
    localparam int HW_W   = 24;           // half width in Q.8 pixels
    localparam int NU_W   = 30;           // normalized delta magnitude
    localparam int SQ_W   = 61;           // sum of squares
    localparam int RT_W   = 62;           // square root working register
    localparam int LEN_W  = 31;           // square root result
    localparam int NUM_W  = 55;           // u * hw + len / 2
    localparam int Q_W    = 25;           // normal component magnitude
    localparam int SQ_STEPS = 31;
    localparam int NORM_MSB = 29;

    localparam logic [16:0]     PPM_MIN        = 17'd1024;
    localparam logic [16:0]     PPM_MAX        = 17'd102400;
    localparam logic [HW_W-1:0] MIN_HALF_WIDTH = 24'd154;
    localparam logic [2:0]      LAST_VTX       = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] REG_CAMERA_X         = 3'd0;
    localparam logic [2:0] REG_CAMERA_Y         = 3'd1;
    localparam logic [2:0] REG_PIXELS_PER_METER = 3'd2;
    localparam logic [2:0] REG_SCREEN_WIDTH     = 3'd3;
    localparam logic [2:0] REG_SCREEN_HEIGHT    = 3'd4;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic [23:0]        line_width;
        logic [31:0]        start_color;
        logic [31:0]        end_color;
    } seg_in_t;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic [31:0]        vertex_color;
        logic               last_vertex;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] camera_x;
        logic signed [31:0] camera_y;
        logic [16:0]        pixels_per_meter;
        logic [13:0]        screen_width;
        logic [13:0]        screen_height;
    } cfg_t;

    // Endpoints and colors that ride along with the normal computation
    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic [31:0]          c1;
        logic [31:0]          c2;
        logic                 nx_neg;
        logic                 ny_neg;
    } side_t;

    typedef struct packed {
        side_t           side;
        logic [HW_W-1:0] hw;
        logic [NU_W-1:0] ux;
        logic [NU_W-1:0] uy;
    } norm_t;

    typedef struct packed {
        norm_t            n;
        logic [LEN_W-1:0] len;
    } len_t;

    typedef struct packed {
        side_t              side;
        logic signed [Q_W:0] nx;
        logic signed [Q_W:0] ny;
    } geom_t;

endpackage

[hw/rtl/tlqe_front.sv]
// Screen transform, half width, delta and normalizing shift stages.
module tlqe_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  tlqe_pkg::cfg_t   cfg,
    input  logic             in_valid,
    input  tlqe_pkg::seg_in_t in_data,
    output logic             out_valid,
    output tlqe_pkg::norm_t  out_data
);
    import tlqe_pkg::*;

    // stage 1: camera offset, scale clamp
    logic v1_reg;
    logic signed [32:0] dsx_reg, dsy_reg, dex_reg, dey_reg;
    logic [16:0] ppm1_reg;
    logic [23:0] lw1_reg;
    logic [31:0] c1a_reg, c2a_reg;
    logic [16:0] ppm_c;

    // stage 2: products
    logic v2_reg;
    logic signed [50:0] psx_reg, psy_reg, pex_reg, pey_reg;
    logic signed [50:0] psx_next, psy_next, pex_next, pey_next;
    logic [40:0] lwp_reg;
    logic [31:0] c1b_reg, c2b_reg;

    // stage 3: round to Q.8 and center
    logic v3_reg;
    side_t s3_reg, s3_next;
    logic [HW_W-1:0] hw3_reg, hw3_next;
    logic signed [50:0] rsx, rsy, rex, rey;
    logic signed [CW-1:0] halfw, halfh;
    logic [41:0] hw_raw;

    // stage 4: delta magnitudes
    logic v4_reg;
    side_t s4_reg, s4_next;
    logic [HW_W-1:0] hw4_reg;
    logic [CW-1:0] ux4_reg, uy4_reg, ux4_next, uy4_next;
    logic signed [CW:0] dx, dy;

    // stage 5: leading one of the larger magnitude
    logic v5_reg;
    side_t s5_reg;
    logic [HW_W-1:0] hw5_reg;
    logic [CW-1:0] ux5_reg, uy5_reg, mx;
    logic [5:0] shr5_reg, shl5_reg, shr_next, shl_next, pos;

    // stage 6: normalized magnitudes
    logic v6_reg;
    norm_t n6_reg, n6_next;

    always_comb begin
        if (cfg.pixels_per_meter < PPM_MIN) begin
            ppm_c = PPM_MIN;
        end else if (cfg.pixels_per_meter > PPM_MAX) begin
            ppm_c = PPM_MAX;
        end else begin
            ppm_c = cfg.pixels_per_meter;
        end
    end

    assign psx_next = dsx_reg * $signed({1'b0, ppm1_reg});
    assign psy_next = dsy_reg * $signed({1'b0, ppm1_reg});
    assign pex_next = dex_reg * $signed({1'b0, ppm1_reg});
    assign pey_next = dey_reg * $signed({1'b0, ppm1_reg});

    // round to nearest, ties up, then shift to screen center
    assign rsx   = (psx_reg + 51'sd32768) >>> 16;
    assign rsy   = (psy_reg + 51'sd32768) >>> 16;
    assign rex   = (pex_reg + 51'sd32768) >>> 16;
    assign rey   = (pey_reg + 51'sd32768) >>> 16;
    assign halfw = $signed(CW'({cfg.screen_width, 7'b0}));
    assign halfh = $signed(CW'({cfg.screen_height, 7'b0}));
    assign hw_raw = 42'(lwp_reg) + 42'd65536;

    always_comb begin
        s3_next.ax     = CW'(rsx) + halfw;
        s3_next.ay     = halfh - CW'(rsy);
        s3_next.bx     = CW'(rex) + halfw;
        s3_next.by     = halfh - CW'(rey);
        s3_next.c1     = c1b_reg;
        s3_next.c2     = c2b_reg;
        s3_next.nx_neg = 1'b0;
        s3_next.ny_neg = 1'b0;
        hw3_next = hw_raw[40:17];
        if (hw3_next < MIN_HALF_WIDTH) begin
            hw3_next = MIN_HALF_WIDTH;
        end
    end

    always_comb begin
        dx = (CW+1)'(s3_reg.bx) - (CW+1)'(s3_reg.ax);
        dy = (CW+1)'(s3_reg.by) - (CW+1)'(s3_reg.ay);
        ux4_next = dx[CW] ? CW'(-dx) : CW'(dx);
        uy4_next = dy[CW] ? CW'(-dy) : CW'(dy);
        s4_next = s3_reg;
        s4_next.nx_neg = !dy[CW] && (dy != '0);
        s4_next.ny_neg = dx[CW];
    end

    // priority encode the top set bit
    always_comb begin
        mx  = (ux4_reg > uy4_reg) ? ux4_reg : uy4_reg;
        pos = '0;
        for (int i = 0; i < CW; i++) begin
            if (mx[i]) begin
                pos = 6'(i);
            end
        end
        shr_next = (pos > 6'(NORM_MSB)) ? pos - 6'(NORM_MSB) : '0;
        shl_next = (pos < 6'(NORM_MSB)) ? 6'(NORM_MSB) - pos : '0;
    end

    always_comb begin
        n6_next.side = s5_reg;
        n6_next.hw   = hw5_reg;
        n6_next.ux   = NU_W'((ux5_reg >> shr5_reg) << shl5_reg);
        n6_next.uy   = NU_W'((uy5_reg >> shr5_reg) << shl5_reg);
    end

    // advance all stages together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            // drop segments with coincident screen endpoints
            v4_reg <= v3_reg && (s3_reg.ax != s3_reg.bx || s3_reg.ay != s3_reg.by);
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dsx_reg  <= 33'(in_data.start_x) - 33'(cfg.camera_x);
            dsy_reg  <= 33'(in_data.start_y) - 33'(cfg.camera_y);
            dex_reg  <= 33'(in_data.end_x) - 33'(cfg.camera_x);
            dey_reg  <= 33'(in_data.end_y) - 33'(cfg.camera_y);
            ppm1_reg <= ppm_c;
            lw1_reg  <= in_data.line_width;
            c1a_reg  <= in_data.start_color;
            c2a_reg  <= in_data.end_color;

            psx_reg <= psx_next;
            psy_reg <= psy_next;
            pex_reg <= pex_next;
            pey_reg <= pey_next;
            lwp_reg <= 41'(lw1_reg) * 41'(ppm1_reg);
            c1b_reg <= c1a_reg;
            c2b_reg <= c2a_reg;

            s3_reg  <= s3_next;
            hw3_reg <= hw3_next;

            s4_reg  <= s4_next;
            hw4_reg <= hw3_reg;
            ux4_reg <= ux4_next;
            uy4_reg <= uy4_next;

            s5_reg   <= s4_reg;
            hw5_reg  <= hw4_reg;
            ux5_reg  <= ux4_reg;
            uy5_reg  <= uy4_reg;
            shr5_reg <= shr_next;
            shl5_reg <= shl_next;

            n6_reg <= n6_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_data  = n6_reg;

endmodule

[hw/rtl/tlqe_sqrt.sv]
// Sum of squares and pipelined integer square root, one result bit per stage.
module tlqe_sqrt (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  tlqe_pkg::norm_t in_data,
    output logic            out_valid,
    output tlqe_pkg::len_t  out_data
);
    import tlqe_pkg::*;

    logic            vq_reg;
    norm_t           nq_reg;
    logic [59:0]     sqx_reg, sqy_reg;

    logic              val_reg [0:SQ_STEPS];
    logic [SQ_W-1:0]   rem_reg [0:SQ_STEPS];
    logic [RT_W-1:0]   rt_reg  [0:SQ_STEPS];
    norm_t             nn_reg  [0:SQ_STEPS];

    // squares, then their sum into the first root stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vq_reg     <= 1'b0;
            val_reg[0] <= 1'b0;
        end else if (en) begin
            vq_reg     <= in_valid;
            val_reg[0] <= vq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nq_reg     <= in_data;
            sqx_reg    <= 60'(in_data.ux) * 60'(in_data.ux);
            sqy_reg    <= 60'(in_data.uy) * 60'(in_data.uy);
            rem_reg[0] <= SQ_W'(sqx_reg) + SQ_W'(sqy_reg);
            rt_reg[0]  <= '0;
            nn_reg[0]  <= nq_reg;
        end
    end

    // one trial subtraction per stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        localparam logic [RT_W-1:0] BIT = RT_W'(1) << (2 * (SQ_STEPS - 1 - k));
        logic [RT_W-1:0] trial;
        logic            ge;

        assign trial = rt_reg[k] + BIT;
        assign ge    = RT_W'(rem_reg[k]) >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                val_reg[k+1] <= 1'b0;
            end else if (en) begin
                val_reg[k+1] <= val_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? rem_reg[k] - trial[SQ_W-1:0] : rem_reg[k];
                rt_reg[k+1]  <= ge ? (rt_reg[k] >> 1) + BIT : rt_reg[k] >> 1;
                nn_reg[k+1]  <= nn_reg[k];
            end
        end
    end

    assign out_valid    = val_reg[SQ_STEPS];
    assign out_data.n   = nn_reg[SQ_STEPS];
    assign out_data.len = rt_reg[SQ_STEPS][LEN_W-1:0];

endmodule

[hw/rtl/tlqe_div.sv]
// Normal components: product with half width, then two pipelined dividers by the length.
module tlqe_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  tlqe_pkg::len_t  in_data,
    output logic            out_valid,
    output tlqe_pkg::geom_t out_data
);
    import tlqe_pkg::*;

    logic              vp_reg;
    len_t              lp_reg;
    logic [53:0]       px_reg, py_reg;

    logic              val_reg [0:Q_W];
    logic [LEN_W-1:0]  rx_reg  [0:Q_W];
    logic [LEN_W-1:0]  ry_reg  [0:Q_W];
    logic [Q_W-1:0]    lx_reg  [0:Q_W];
    logic [Q_W-1:0]    ly_reg  [0:Q_W];
    logic [Q_W-1:0]    qx_reg  [0:Q_W];
    logic [Q_W-1:0]    qy_reg  [0:Q_W];
    logic [LEN_W-1:0]  dv_reg  [0:Q_W];
    side_t             sd_reg  [0:Q_W];

    logic [NUM_W-1:0]  numx, numy;

    // nx magnitude uses |dy|, ny magnitude uses |dx|; add len/2 to round
    assign numx = NUM_W'(px_reg) + NUM_W'(lp_reg.len >> 1);
    assign numy = NUM_W'(py_reg) + NUM_W'(lp_reg.len >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg     <= 1'b0;
            val_reg[0] <= 1'b0;
        end else if (en) begin
            vp_reg     <= in_valid;
            val_reg[0] <= vp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lp_reg <= in_data;
            px_reg <= 54'(in_data.n.uy) * 54'(in_data.n.hw);
            py_reg <= 54'(in_data.n.ux) * 54'(in_data.n.hw);
            rx_reg[0] <= LEN_W'(numx[NUM_W-1:Q_W]);
            ry_reg[0] <= LEN_W'(numy[NUM_W-1:Q_W]);
            lx_reg[0] <= numx[Q_W-1:0];
            ly_reg[0] <= numy[Q_W-1:0];
            qx_reg[0] <= '0;
            qy_reg[0] <= '0;
            dv_reg[0] <= lp_reg.len;
            sd_reg[0] <= lp_reg.n.side;
        end
    end

    // restoring division, one quotient bit per stage for each component
    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [LEN_W:0] shx, shy;
        logic           gex, gey;

        assign shx = {rx_reg[k], lx_reg[k][Q_W-1]};
        assign shy = {ry_reg[k], ly_reg[k][Q_W-1]};
        assign gex = shx >= {1'b0, dv_reg[k]};
        assign gey = shy >= {1'b0, dv_reg[k]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                val_reg[k+1] <= 1'b0;
            end else if (en) begin
                val_reg[k+1] <= val_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rx_reg[k+1] <= gex ? LEN_W'(shx - {1'b0, dv_reg[k]}) : LEN_W'(shx);
                ry_reg[k+1] <= gey ? LEN_W'(shy - {1'b0, dv_reg[k]}) : LEN_W'(shy);
                lx_reg[k+1] <= lx_reg[k] << 1;
                ly_reg[k+1] <= ly_reg[k] << 1;
                qx_reg[k+1] <= {qx_reg[k][Q_W-2:0], gex};
                qy_reg[k+1] <= {qy_reg[k][Q_W-2:0], gey};
                dv_reg[k+1] <= dv_reg[k];
                sd_reg[k+1] <= sd_reg[k];
            end
        end
    end

    // apply signs
    always_comb begin
        out_data.side = sd_reg[Q_W];
        out_data.nx   = sd_reg[Q_W].nx_neg ? -$signed({1'b0, qx_reg[Q_W]})
                                           : $signed({1'b0, qx_reg[Q_W]});
        out_data.ny   = sd_reg[Q_W].ny_neg ? -$signed({1'b0, qy_reg[Q_W]})
                                           : $signed({1'b0, qy_reg[Q_W]});
    end

    assign out_valid = val_reg[Q_W];

endmodule

[hw/rtl/tlqe_emit.sv]
// Vertex sequencer: holds one segment and sends its six vertices through an output register.
module tlqe_emit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  tlqe_pkg::geom_t in_data,
    output logic            can_load,
    output logic            m_valid,
    input  logic            m_ready,
    output tlqe_pkg::vertex_t m_data
);
    import tlqe_pkg::*;

    logic        busy_reg, busy_next;
    logic [2:0]  cnt_reg, cnt_next;
    geom_t       g_reg;
    logic        m_valid_reg, m_valid_next;
    vertex_t     m_data_reg, vtx;
    logic        out_free, load, send;
    logic        use_b, neg;
    logic signed [CW-1:0] bx, by;
    logic signed [Q_W:0]  ox, oy;
    logic signed [CW+1:0] sx, sy;

    assign out_free = !m_valid_reg || m_ready;
    assign send     = busy_reg && out_free;
    assign can_load = !busy_reg || (out_free && cnt_reg == LAST_VTX);
    assign load     = in_valid && can_load;

    // pick endpoint and sign of the normal for this vertex
    always_comb begin
        case (cnt_reg)
            3'd0:    begin use_b = 1'b0; neg = 1'b0; end
            3'd1:    begin use_b = 1'b0; neg = 1'b1; end
            3'd2:    begin use_b = 1'b1; neg = 1'b1; end
            3'd3:    begin use_b = 1'b0; neg = 1'b0; end
            3'd4:    begin use_b = 1'b1; neg = 1'b1; end
            default: begin use_b = 1'b1; neg = 1'b0; end
        endcase
        bx = use_b ? g_reg.side.bx : g_reg.side.ax;
        by = use_b ? g_reg.side.by : g_reg.side.ay;
        ox = neg ? -g_reg.nx : g_reg.nx;
        oy = neg ? -g_reg.ny : g_reg.ny;
        sx = (CW+2)'(bx) + (CW+2)'(ox) - (CW+2)'(128);
        sy = (CW+2)'(by) + (CW+2)'(oy) - (CW+2)'(128);
        // saturate to the signed 32 bit range
        if (sx > (CW+2)'(32'sh7FFFFFFF)) begin
            vtx.vertex_x = 32'sh7FFFFFFF;
        end else if (sx < -(CW+2)'(33'sh080000000)) begin
            vtx.vertex_x = 32'sh80000000;
        end else begin
            vtx.vertex_x = 32'(sx);
        end
        if (sy > (CW+2)'(32'sh7FFFFFFF)) begin
            vtx.vertex_y = 32'sh7FFFFFFF;
        end else if (sy < -(CW+2)'(33'sh080000000)) begin
            vtx.vertex_y = 32'sh80000000;
        end else begin
            vtx.vertex_y = 32'(sy);
        end
        vtx.vertex_color = use_b ? g_reg.side.c2 : g_reg.side.c1;
        vtx.last_vertex  = (cnt_reg == LAST_VTX);
    end

    always_comb begin
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (send) begin
            m_valid_next = 1'b1;
            cnt_next     = cnt_reg + 3'd1;
            if (cnt_reg == LAST_VTX) begin
                busy_next = 1'b0;
            end
        end
        if (load) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // hold the segment and the outgoing vertex
    always_ff @(posedge aclk) begin
        if (load) begin
            g_reg <= in_data;
        end
        if (send) begin
            m_data_reg <= vtx;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg <= LAST_VTX)
        else $error("vertex counter out of range");

    a_load_start: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> busy_reg && cnt_reg == 3'd0)
        else $error("segment load did not restart the sequence");

    a_no_early_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cnt_reg != LAST_VTX) |-> !load)
        else $error("segment loaded before the last vertex was sent");

endmodule

[hw/rtl/thick_line_quad_expander_top.sv]
// Top level of the thick line quad expander: configuration registers and pipeline.
//
// Input channel s_valid/s_ready/s_data carries one line segment per transfer
// (world endpoints, width, two colors). Output channel m_valid/m_ready/m_data
// carries vertices, six per segment forming two triangles, last_vertex marking
// the sixth. A segment whose screen endpoints coincide produces no vertices.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; write
// only while no segment is in flight.
// From input transfer to the first vertex transfer a segment passes the
// transform, square root and divider pipelines, then the segment and vertex registers.
// The single vertex output limits the segment rate, as it sends six vertices
// per segment; the pipeline accepts a new segment every cycle until its tail
// holds a segment waiting for the vertex sequencer.
// Reset (aresetn low, synchronous) empties the pipeline and restores camera
// 0,0, scale 32 pixels per meter, screen 1280 by 720.
// A receiver stall holds the pipeline once its tail has a waiting segment; nothing is dropped.
module thick_line_quad_expander_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tlqe_pkg::seg_in_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tlqe_pkg::vertex_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import tlqe_pkg::*;

    cfg_t  cfg_reg;
    logic  en, can_load;
    logic  fv, sv, dv;
    norm_t fd;
    len_t  sd;
    geom_t dd;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.camera_x         <= '0;
            cfg_reg.camera_y         <= '0;
            cfg_reg.pixels_per_meter <= 17'd8192;
            cfg_reg.screen_width     <= 14'd1280;
            cfg_reg.screen_height    <= 14'd720;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CAMERA_X:         cfg_reg.camera_x <= cfg_data;
                REG_CAMERA_Y:         cfg_reg.camera_y <= cfg_data;
                REG_PIXELS_PER_METER: cfg_reg.pixels_per_meter <= cfg_data[16:0];
                REG_SCREEN_WIDTH:     cfg_reg.screen_width <= cfg_data[13:0];
                REG_SCREEN_HEIGHT:    cfg_reg.screen_height <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // pipeline advances unless its tail holds a segment the sequencer cannot take
    assign en      = !dv || can_load;
    assign s_ready = en;

    tlqe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .cfg      (cfg_reg),
        .in_valid (s_valid),
        .in_data  (s_data),
        .out_valid(fv),
        .out_data (fd)
    );

    tlqe_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (fv),
        .in_data  (fd),
        .out_valid(sv),
        .out_data (sd)
    );

    tlqe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (sv),
        .in_data  (sd),
        .out_valid(dv),
        .out_data (dd)
    );

    tlqe_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (dv),
        .in_data  (dd),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
